[sv/lips_pkg.sv]
// Shared types, sizes and codes for the LED indicator priority selector.
// Used by lips_cell, lips_ctrl and led_indicator_priority_select; no dependencies.
package lips_pkg;

	localparam int LED_COUNT   = 4;
	localparam int STATE_COUNT = 20;
	localparam int PRIO_WIDTH  = 8;

	localparam int LED_IW = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
	localparam int ST_IW  = $clog2(STATE_COUNT);

	localparam logic [ST_IW-1:0] IDLE_STATE = '0;

	localparam logic [7:0] PRIO_DEFAULT_RST = 8'd254;
	localparam logic [7:0] PRIO_DISABLE_RST = 8'd255;

	localparam int CFG_AW = 3;
	localparam int CFG_DW = 32;
	localparam logic REG_DEFAULT = 1'b0;
	localparam logic REG_DISABLE = 1'b1;

	localparam logic [2:0] CMD_SET    = 3'd0;
	localparam logic [2:0] CMD_CLEAR  = 3'd1;
	localparam logic [2:0] CMD_RSTALL = 3'd2;
	localparam logic [2:0] CMD_GET    = 3'd3;
	localparam logic [2:0] CMD_LOAD   = 3'd4;

	localparam logic [1:0] STAT_DONE     = 2'd0;
	localparam logic [1:0] STAT_IGNORED  = 2'd1;
	localparam logic [1:0] STAT_REJECTED = 2'd2;

	localparam logic [2:0] WR_NONE   = 3'd0;
	localparam logic [2:0] WR_SET    = 3'd1;
	localparam logic [2:0] WR_CLEAR  = 3'd2;
	localparam logic [2:0] WR_RSTALL = 3'd3;
	localparam logic [2:0] WR_LOAD   = 3'd4;

	typedef struct packed {
		logic [2:0] cmd;
		logic [4:0] state_id;
		logic [7:0] priority_req;
		logic [2:0] position;
	} in_beat_t;

	typedef struct packed {
		logic [1:0] status;
		logic [2:0] led_position;
		logic [4:0] active_state;
		logic [7:0] active_prio;
		logic       changed;
		logic       last_of_run;
	} out_beat_t;

	typedef struct packed {
		logic [2:0]            op;
		logic [LED_IW-1:0]     led;
		logic [ST_IW-1:0]      sid;
		logic [PRIO_WIDTH-1:0] val;
		logic [PRIO_WIDTH-1:0] def;
		logic [PRIO_WIDTH-1:0] dis;
	} wr_t;

	typedef struct packed {
		logic [LED_IW-1:0]     led;
		logic [PRIO_WIDTH-1:0] best;
		logic [ST_IW-1:0]      pick;
		logic [PRIO_WIDTH-1:0] idle_prio;
	} tok_t;

	function automatic logic [PRIO_WIDTH-1:0] to_prio(input logic [7:0] v);
		logic [31:0] w;
		w = {24'd0, v};
		return w[PRIO_WIDTH-1:0];
	endfunction

	function automatic logic [7:0] prio_to8(input logic [PRIO_WIDTH-1:0] p);
		logic [31:0] w;
		w = 32'(p);
		return w[7:0];
	endfunction

endpackage

[sv/led_indicator_priority_select.sv]
// LED indicator priority selector, top level: APB registers, the row of state cells and
// the command sequencer. Depends on lips_pkg, lips_cell and lips_ctrl.
//
// Each LED shows the enabled indicator state with the lowest stored priority below the
// default code, lowest index first, idle otherwise. The tables live in a row of one cell
// per state, and a search token moves one cell per clock, so the row length sets the
// latency. A command is taken while idle and decoded in the next cycle; get, load,
// ignored and rejected commands then give their result beat. Set and clear add a walk
// of one token through the row. Reset all sends one token per LED on back-to-back
// cycles and, once the walk is through, one result beat per LED in ascending order.
// A new command is taken once the last result of the previous one sits in the output
// register. Tables come out of reset ready for use.
module led_indicator_priority_select (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  lips_pkg::in_beat_t              in_data,
	output logic                            out_valid,
	input  logic                            out_stall,
	output lips_pkg::out_beat_t             out_data,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [lips_pkg::CFG_AW-1:0]     paddr,
	input  logic [lips_pkg::CFG_DW-1:0]     pwdata,
	output logic [lips_pkg::CFG_DW-1:0]     prdata,
	output logic                            pready
);
	import lips_pkg::*;

	logic [7:0] def_code_q;
	logic [7:0] dis_code_q;
	logic       cfg_wr;

	wr_t                                   wr;
	logic                                  tok_valid [STATE_COUNT+1];
	tok_t                                  tok       [STATE_COUNT+1];
	logic [STATE_COUNT-1:0][PRIO_WIDTH-1:0] dflt_all;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = {24'd0, (paddr[2] == REG_DISABLE) ? dis_code_q : def_code_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			def_code_q <= PRIO_DEFAULT_RST;
			dis_code_q <= PRIO_DISABLE_RST;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_DEFAULT) begin
				def_code_q <= pwdata[7:0];
			end else begin
				dis_code_q <= pwdata[7:0];
			end
		end
	end

	lips_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_data    (out_data),
		.def_code    (def_code_q),
		.dis_code    (dis_code_q),
		.dflt_all    (dflt_all),
		.wr          (wr),
		.start_valid (tok_valid[0]),
		.start_tok   (tok[0]),
		.ret_valid   (tok_valid[STATE_COUNT]),
		.ret_tok     (tok[STATE_COUNT])
	);

	for (genvar i = 0; i < STATE_COUNT; i++) begin : g_cell
		lips_cell u_cell (
			.clk           (clk),
			.arst_n        (arst_n),
			.cell_idx      (ST_IW'(i)),
			.wr            (wr),
			.tok_valid_in  (tok_valid[i]),
			.tok_in        (tok[i]),
			.tok_valid_out (tok_valid[i+1]),
			.tok_out       (tok[i+1]),
			.dflt          (dflt_all[i])
		);
	end

endmodule

[sv/lips_cell.sv]
// One state cell: enable bits and priorities of one state for every LED, plus its default.
// The search token is registered in each cell as it passes. Depends on lips_pkg.
module lips_cell (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [lips_pkg::ST_IW-1:0]      cell_idx,
	input  lips_pkg::wr_t                   wr,
	input  logic                            tok_valid_in,
	input  lips_pkg::tok_t                  tok_in,
	output logic                            tok_valid_out,
	output lips_pkg::tok_t                  tok_out,
	output logic [lips_pkg::PRIO_WIDTH-1:0] dflt
);
	import lips_pkg::*;

	logic                  en_q   [LED_COUNT];
	logic [PRIO_WIDTH-1:0] prio_q [LED_COUNT];
	logic [PRIO_WIDTH-1:0] dflt_q;
	logic                  is_idle;
	logic                  hit;
	logic [PRIO_WIDTH-1:0] rst_prio;
	tok_t                  nxt;

	assign is_idle  = cell_idx == IDLE_STATE;
	assign hit      = wr.sid == cell_idx;
	assign rst_prio = is_idle ? to_prio(PRIO_DEFAULT_RST) : to_prio(PRIO_DISABLE_RST);
	assign dflt     = dflt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int l = 0; l < LED_COUNT; l++) begin
				en_q[l]   <= is_idle;
				prio_q[l] <= rst_prio;
			end
			dflt_q <= rst_prio;
		end else begin
			case (wr.op)
				WR_SET: begin
					if (hit) begin
						en_q[wr.led]   <= 1'b1;
						prio_q[wr.led] <= (wr.val == wr.def) ? dflt_q : wr.val;
					end
				end
				WR_CLEAR: begin
					if (hit) begin
						en_q[wr.led]   <= 1'b0;
						prio_q[wr.led] <= wr.dis;
					end
				end
				WR_RSTALL: begin
					for (int l = 0; l < LED_COUNT; l++) begin
						en_q[l]   <= is_idle;
						prio_q[l] <= is_idle ? dflt_q : wr.dis;
					end
				end
				WR_LOAD: begin
					if (hit) begin
						dflt_q <= (is_idle && wr.val == wr.dis) ? wr.def : wr.val;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		nxt = tok_in;
		if (is_idle) begin
			nxt.idle_prio = prio_q[tok_in.led];
		end
		if (en_q[tok_in.led] && prio_q[tok_in.led] < tok_in.best) begin
			nxt.best = prio_q[tok_in.led];
			nxt.pick = cell_idx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_valid_out <= 1'b0;
		end else begin
			tok_valid_out <= tok_valid_in;
		end
	end

	always_ff @(posedge clk) begin
		tok_out <= nxt;
	end

endmodule

[sv/lips_ctrl.sv]
// Command sequencer: decodes each command, drives table writes into the cell row,
// launches search tokens, keeps the shown state per LED and issues result beats.
// Depends on lips_pkg.
module lips_ctrl (
	input  logic                                               clk,
	input  logic                                               arst_n,
	input  logic                                               in_valid,
	output logic                                               in_stall,
	input  lips_pkg::in_beat_t                                 in_data,
	output logic                                               out_valid,
	input  logic                                               out_stall,
	output lips_pkg::out_beat_t                                out_data,
	input  logic [7:0]                                         def_code,
	input  logic [7:0]                                         dis_code,
	input  logic [lips_pkg::STATE_COUNT-1:0][lips_pkg::PRIO_WIDTH-1:0] dflt_all,
	output lips_pkg::wr_t                                      wr,
	output logic                                               start_valid,
	output lips_pkg::tok_t                                     start_tok,
	input  logic                                               ret_valid,
	input  lips_pkg::tok_t                                     ret_tok
);
	import lips_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_WALK = 2'd2;
	localparam logic [1:0] S_SEND = 2'd3;

	logic [1:0]            state_q;
	in_beat_t              cmd_q;
	logic [ST_IW-1:0]      shown_q      [LED_COUNT];
	logic [PRIO_WIDTH-1:0] shown_prio_q [LED_COUNT];
	logic                  chg_q        [LED_COUNT];
	logic                  start_valid_q;
	logic [LED_IW-1:0]     start_led_q;
	logic [LED_IW-1:0]     emit_led_q;
	logic [LED_IW-1:0]     emit_end_q;
	logic                  walk_mode_q;
	out_beat_t             imm_q;
	logic                  out_valid_q;
	out_beat_t             out_q;

	logic                  accept;
	logic                  slot_free;
	logic [PRIO_WIDTH-1:0] def_p;
	logic [PRIO_WIDTH-1:0] dis_p;
	logic                  pos_ok;
	logic                  sid_ok;
	logic [LED_IW-1:0]     pos_i;
	logic [ST_IW-1:0]      sid_i;
	logic [PRIO_WIDTH-1:0] sid_dflt;
	logic [2:0]            dec_op;
	logic                  dec_walk;
	logic [1:0]            dec_status;
	out_beat_t             imm;
	out_beat_t             walk_res;
	logic                  is_rstall;
	logic                  emit_last;

	assign accept    = in_valid && !in_stall;
	assign in_stall  = state_q != S_IDLE;
	assign slot_free = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign def_p     = to_prio(def_code);
	assign dis_p     = to_prio(dis_code);
	assign pos_ok    = {1'b0, cmd_q.position} < 4'(LED_COUNT);
	assign sid_ok    = {1'b0, cmd_q.state_id} < 6'(STATE_COUNT);
	assign pos_i     = cmd_q.position[LED_IW-1:0];
	assign sid_i     = cmd_q.state_id[ST_IW-1:0];
	assign sid_dflt  = dflt_all[sid_i];
	assign is_rstall = cmd_q.cmd == CMD_RSTALL;
	assign emit_last = emit_led_q == emit_end_q;

	always_comb begin
		dec_op     = WR_NONE;
		dec_walk   = 1'b0;
		dec_status = STAT_REJECTED;
		case (cmd_q.cmd)
			CMD_SET, CMD_CLEAR: begin
				if (!pos_ok || !sid_ok || (cmd_q.cmd == CMD_CLEAR && sid_i == IDLE_STATE)) begin
					dec_status = STAT_REJECTED;
				end else if (sid_dflt == dis_p) begin
					dec_status = STAT_IGNORED;
				end else begin
					dec_op     = (cmd_q.cmd == CMD_SET) ? WR_SET : WR_CLEAR;
					dec_walk   = 1'b1;
					dec_status = STAT_DONE;
				end
			end
			CMD_RSTALL: begin
				dec_op     = WR_RSTALL;
				dec_walk   = 1'b1;
				dec_status = STAT_DONE;
			end
			CMD_GET: begin
				dec_status = pos_ok ? STAT_DONE : STAT_REJECTED;
			end
			CMD_LOAD: begin
				if (sid_ok) begin
					dec_op     = WR_LOAD;
					dec_status = STAT_DONE;
				end
			end
			default: begin
				dec_status = STAT_REJECTED;
			end
		endcase
	end

	always_comb begin
		wr.op  = (state_q == S_EXEC) ? dec_op : WR_NONE;
		wr.led = pos_i;
		wr.sid = sid_i;
		wr.val = to_prio(cmd_q.priority_req);
		wr.def = def_p;
		wr.dis = dis_p;
	end

	always_comb begin
		imm.status       = dec_status;
		imm.led_position = cmd_q.position;
		imm.active_state = pos_ok ? 5'(shown_q[pos_i]) : 5'd0;
		imm.active_prio  = pos_ok ? prio_to8(shown_prio_q[pos_i]) : 8'd0;
		imm.changed      = 1'b0;
		imm.last_of_run  = 1'b1;

		walk_res.status       = STAT_DONE;
		walk_res.led_position = 3'(emit_led_q);
		walk_res.active_state = 5'(shown_q[emit_led_q]);
		walk_res.active_prio  = prio_to8(shown_prio_q[emit_led_q]);
		walk_res.changed      = chg_q[emit_led_q];
		walk_res.last_of_run  = emit_last;
	end

	assign start_valid         = start_valid_q;
	assign start_tok.led       = start_led_q;
	assign start_tok.best      = def_p;
	assign start_tok.pick      = IDLE_STATE;
	assign start_tok.idle_prio = def_p;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			start_valid_q <= 1'b0;
			start_led_q   <= '0;
			emit_led_q    <= '0;
			emit_end_q    <= '0;
			walk_mode_q   <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (state_q == S_SEND && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					walk_mode_q <= dec_walk;
					if (dec_walk) begin
						start_valid_q <= 1'b1;
						start_led_q   <= is_rstall ? '0 : pos_i;
						emit_led_q    <= is_rstall ? '0 : pos_i;
						emit_end_q    <= is_rstall ? LED_IW'(LED_COUNT - 1) : pos_i;
						state_q       <= S_WALK;
					end else begin
						state_q <= S_SEND;
					end
				end
				S_WALK: begin
					if (start_valid_q) begin
						if (start_led_q == emit_end_q) begin
							start_valid_q <= 1'b0;
						end else begin
							start_led_q <= start_led_q + LED_IW'(1);
						end
					end
					if (ret_valid && ret_tok.led == emit_end_q) begin
						state_q <= S_SEND;
					end
				end
				S_SEND: begin
					if (slot_free) begin
						if (walk_mode_q && !emit_last) begin
							emit_led_q <= emit_led_q + LED_IW'(1);
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= in_data;
		end
		if (state_q == S_EXEC) begin
			imm_q <= imm;
		end
		if (state_q == S_SEND && slot_free) begin
			out_q <= walk_mode_q ? walk_res : imm_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int l = 0; l < LED_COUNT; l++) begin
				shown_q[l]      <= IDLE_STATE;
				shown_prio_q[l] <= to_prio(PRIO_DEFAULT_RST);
				chg_q[l]        <= 1'b0;
			end
		end else if (ret_valid) begin
			shown_q[ret_tok.led]      <= ret_tok.pick;
			shown_prio_q[ret_tok.led] <= (ret_tok.pick == IDLE_STATE) ?
				ret_tok.idle_prio : ret_tok.best;
			chg_q[ret_tok.led]        <= ret_tok.pick != shown_q[ret_tok.led];
		end
	end

endmodule
